// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the compositor controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled in reset.
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/afc_pkg.sv =====
package afc_pkg;

    localparam int unsigned MAX_WIDTH  = 64;
    localparam int unsigned MAX_HEIGHT = 32;

    localparam logic [1:0] ACT_FRAME  = 2'd0;
    localparam logic [1:0] ACT_PIXEL  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic REG_CANVAS_W = 1'b0;
    localparam logic REG_CANVAS_H = 1'b1;

    localparam logic [7:0] ALPHA_FULL = 8'd255;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  frame_x;
        logic [4:0]  frame_y;
        logic [6:0]  frame_width;
        logic [5:0]  frame_height;
        logic        alpha_present;
        logic        blend_over;
        logic        dispose_background;
        logic [31:0] pixel_rgba;
        logic [5:0]  read_x;
        logic [4:0]  read_y;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
        logic       key_frame;
        logic       clipped;
    } t_out_item;

    // controller -> datapath commands
    typedef struct packed {
        logic load_item;   // capture input item
        logic clr_start;   // begin a clear sweep of the current rectangle
        logic clr_step;    // sweep one pixel
        logic frame_done;  // commit frame-start bookkeeping
        logic mem_rd;      // read canvas at item address
        logic mem_wr;      // write canvas at item address
        logic pix_adv;     // advance raster position
        logic result;      // emit result
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic init_run;      // post-reset canvas clear in progress
        logic action_frame;
        logic action_pixel;
        logic action_read;
        logic need_disp;     // previous frame disposes to background
        logic key;           // new frame judged key
        logic clr_last;      // sweep at last pixel
        logic pix_in;        // pixel lands on canvas
        logic pix_need_rd;   // pixel requires blending read
    } t_status;

    // (s*a + d*(255-a)) / 255 via reciprocal and correction
    function automatic logic [7:0] mix255(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] a);
        logic [16:0] sum;
        logic [16:0] q;
        logic [16:0] r;
        begin
            sum = 17'({9'd0, s} * {9'd0, a}) + 17'({9'd0, d} * {9'd0, 8'd255 - a});
            q = 17'((25'({8'd0, sum}) * 25'd257) >> 16);
            r = sum - 17'(q * 17'd255);
            if (r >= 17'd255) q = q + 17'd1;
            mix255 = q[7:0];
        end
    endfunction

endpackage

// ===== hdl/afc_ctrl.sv =====
`include "assert_macros.svh"

module afc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  afc_pkg::t_status i_st,
    output afc_pkg::t_cmd   o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_DEC   = 8'b00000010,
        S_DISP  = 8'b00000100,
        S_KEYCK = 8'b00001000,
        S_KEY   = 8'b00010000,
        S_RD    = 8'b00100000,
        S_WR    = 8'b01000000,
        S_INIT  = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_INIT: begin
                if (!i_st.init_run) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_st.action_frame) begin
                    if (i_st.need_disp) begin
                        o_cmd.clr_start = 1'b1;
                        n_state = S_DISP;
                    end else begin
                        n_state = S_KEYCK;
                    end
                end else if (i_st.action_pixel && i_st.pix_in) begin
                    if (i_st.pix_need_rd) begin
                        o_cmd.mem_rd = 1'b1;
                        n_state = S_RD;
                    end else begin
                        o_cmd.mem_wr = 1'b1;
                        o_cmd.pix_adv = 1'b1;
                        o_cmd.result = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (i_st.action_read) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state = S_RD;
                end else begin
                    o_cmd.pix_adv = i_st.action_pixel;
                    o_cmd.result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DISP: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) n_state = S_KEYCK;
            end
            S_KEYCK: begin
                if (i_st.key) begin
                    o_cmd.clr_start = 1'b1;
                    n_state = S_KEY;
                end else begin
                    o_cmd.frame_done = 1'b1;
                    o_cmd.result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_KEY: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) begin
                    o_cmd.frame_done = 1'b1;
                    o_cmd.result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                // read data is registered now
                if (i_st.action_pixel) begin
                    o_cmd.mem_wr = 1'b1;
                    o_cmd.pix_adv = 1'b1;
                end
                o_cmd.result = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `AST_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy,
              "accepted item did not make block busy")
    `AST_IMPL(a_one_result, i_clk, i_rst_n, o_cmd.result, o_busy,
              "result while idle")
    `AST_IMPL(a_no_wr_clear, i_clk, i_rst_n, o_cmd.clr_step, !o_cmd.mem_wr,
              "pixel write during clear sweep")

endmodule

// ===== hdl/afc_datapath.sv =====
module afc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [6:0]         i_cfg_data,
    input  afc_pkg::t_in_item  i_item,
    input  afc_pkg::t_cmd      i_cmd,
    output afc_pkg::t_status   o_st,
    output logic               o_valid,
    output afc_pkg::t_out_item o_res
);

    localparam int unsigned MAX_WIDTH  = afc_pkg::MAX_WIDTH;
    localparam int unsigned MAX_HEIGHT = afc_pkg::MAX_HEIGHT;
    localparam int unsigned XW = $clog2(MAX_WIDTH);
    localparam int unsigned YW = $clog2(MAX_HEIGHT);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned AW = XW + YW;

    logic [6:0] r_cw_raw;
    logic [5:0] r_ch_raw;
    logic [WW-1:0] cw;
    logic [HW-1:0] ch;

    afc_pkg::t_in_item r_item;

    logic [XW-1:0] r_rl;
    logic [YW-1:0] r_rt;
    logic [WW-1:0] r_rw;
    logic [HW-1:0] r_rh;
    logic [XW-1:0] r_pcol;
    logic [YW:0]   r_prow;
    logic r_blend, r_key, r_seen, r_pdisp, r_pkey;

    // clear sweep
    logic [XW-1:0] r_cl;
    logic [YW-1:0] r_ct;
    logic [WW-1:0] r_cwid;
    logic [HW-1:0] r_chgt;
    logic [WW-1:0] r_cx;
    logic [HW-1:0] r_cy;
    logic r_cempty;

    // clear start from the decode state (dispose) selects the old rectangle; from the key check
    // it selects the full canvas
    logic key_now_sel;
    logic r_disp_done;

    // post-reset canvas clear
    logic [AW-1:0] r_init_cnt;
    logic r_init_run;

    logic [23:0] r_mem [MAX_WIDTH*MAX_HEIGHT];
    logic [23:0] r_rdata;

    logic [WW-1:0] fw;
    logic [HW-1:0] fh;
    logic key_now;
    logic [WW:0] px, clx;
    logic [HW:0] py, cly;
    logic pix_ok, pix_in;
    logic [AW-1:0] pix_addr, rd_addr, clr_addr;
    logic [XW-1:0] pa_x;
    logic [YW-1:0] pa_y;
    logic rd_in;
    logic [WW-1:0] sat_cw;
    logic [HW-1:0] sat_ch;
    logic [7:0] a;
    logic [23:0] wdata, blended;
    logic [WW-1:0] nxt_col;

    // effective canvas size
    always_comb begin
        if (r_cw_raw == 7'd0) sat_cw = WW'(1);
        else if (32'(r_cw_raw) > MAX_WIDTH) sat_cw = WW'(MAX_WIDTH);
        else sat_cw = WW'(r_cw_raw);
        if (r_ch_raw == 6'd0) sat_ch = HW'(1);
        else if (32'(r_ch_raw) > MAX_HEIGHT) sat_ch = HW'(MAX_HEIGHT);
        else sat_ch = HW'(r_ch_raw);
    end
    assign cw = sat_cw;
    assign ch = sat_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw_raw <= 7'd64;
            r_ch_raw <= 6'd32;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == afc_pkg::REG_CANVAS_W) r_cw_raw <= i_cfg_data;
            else r_cw_raw <= r_cw_raw;
            if (i_cfg_idx == afc_pkg::REG_CANVAS_H) r_ch_raw <= i_cfg_data[5:0];
        end
    end

    always_comb begin
        fw = (32'(r_item.frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_item.frame_width);
        fh = (32'(r_item.frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
                                                       : HW'(r_item.frame_height);
        if (!r_seen) key_now = 1'b1;
        else if ((!r_item.alpha_present || !r_item.blend_over) && fw == cw && fh == ch)
            key_now = 1'b1;
        else key_now = r_pdisp && ((r_rw == cw && r_rh == ch) || r_pkey);
    end

    // pixel placement
    always_comb begin
        px = (WW+1)'(r_rl) + (WW+1)'(r_pcol);
        py = (HW+1)'(r_rt) + (HW+1)'(r_prow);
        pix_ok = (r_rw != '0) && ((HW+1)'(r_prow) < (HW+1)'(r_rh));
        pix_in = pix_ok && (px < (WW+1)'(cw)) && (py < (HW+1)'(ch));
        pa_x = px[XW-1:0];
        pa_y = py[YW-1:0];
        pix_addr = {pa_y, pa_x};
        rd_in = (32'(r_item.read_x) < 32'(cw)) && (32'(r_item.read_y) < 32'(ch));
        rd_addr = {YW'(r_item.read_y), XW'(r_item.read_x)};
        clx = (WW+1)'(r_cl) + (WW+1)'(r_cx);
        cly = (HW+1)'(r_ct) + (HW+1)'(r_cy);
        clr_addr = {cly[YW-1:0], clx[XW-1:0]};
        nxt_col = WW'(r_pcol) + WW'(1);
    end

    always_comb begin
        o_st.init_run     = r_init_run;
        o_st.action_frame = (r_item.action == afc_pkg::ACT_FRAME);
        o_st.action_pixel = (r_item.action == afc_pkg::ACT_PIXEL);
        o_st.action_read  = (r_item.action == afc_pkg::ACT_READ);
        o_st.need_disp    = r_seen && r_pdisp;
        o_st.key          = key_now;
        o_st.pix_in       = pix_in;
        a = r_item.pixel_rgba[7:0];
        o_st.pix_need_rd  = r_blend && (a != afc_pkg::ALPHA_FULL);
        // sweep ends at last in-canvas pixel of the rectangle, or at once if it is empty
        o_st.clr_last = r_cempty ||
                        (((clx + 1'b1 >= (WW+1)'(cw)) || (r_cx + 1'b1 >= r_cwid)) &&
                         ((cly + 1'b1 >= (HW+1)'(ch)) || (r_cy + 1'b1 >= r_chgt)));
    end

    always_comb begin
        blended = {afc_pkg::mix255(r_item.pixel_rgba[31:24], r_rdata[23:16], a),
                   afc_pkg::mix255(r_item.pixel_rgba[23:16], r_rdata[15:8], a),
                   afc_pkg::mix255(r_item.pixel_rgba[15:8],  r_rdata[7:0], a)};
        if (!r_blend || a == afc_pkg::ALPHA_FULL) wdata = r_item.pixel_rgba[31:8];
        else if (a == 8'd0) wdata = r_rdata;
        else wdata = blended;
    end

    // walk every canvas entry once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cnt <= '0;
            r_init_run <= 1'b1;
        end else if (r_init_run) begin
            r_init_cnt <= r_init_cnt + 1'b1;
            if (r_init_cnt == '1) r_init_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) r_item <= i_item;
        if (r_init_run) r_mem[r_init_cnt] <= '0;
        else if (i_cmd.clr_step && !r_cempty) r_mem[clr_addr] <= '0;
        else if (i_cmd.mem_wr) r_mem[pix_addr] <= wdata;
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[o_st.action_read ? rd_addr : pix_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rl <= '0; r_rt <= '0; r_rw <= '0; r_rh <= '0;
            r_pcol <= '0; r_prow <= '0;
            r_blend <= 1'b0; r_key <= 1'b0; r_seen <= 1'b0;
            r_pdisp <= 1'b0; r_pkey <= 1'b0;
            r_cl <= '0; r_ct <= '0; r_cwid <= '0; r_chgt <= '0;
            r_cx <= '0; r_cy <= '0; r_cempty <= 1'b1;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.result;
            if (i_cmd.clr_start) begin
                r_cx <= '0;
                r_cy <= '0;
                if (!key_now_sel) begin
                    r_cl <= r_rl; r_ct <= r_rt; r_cwid <= r_rw; r_chgt <= r_rh;
                    r_cempty <= (r_rw == '0) || (r_rh == '0) ||
                                (32'(r_rl) >= 32'(cw)) || (32'(r_rt) >= 32'(ch));
                end else begin
                    r_cl <= '0; r_ct <= '0; r_cwid <= cw; r_chgt <= ch;
                    r_cempty <= 1'b0;
                end
            end else if (i_cmd.clr_step && !r_cempty) begin
                if ((clx + 1'b1 >= (WW+1)'(cw)) || (r_cx + 1'b1 >= r_cwid)) begin
                    r_cx <= '0;
                    r_cy <= r_cy + 1'b1;
                end else begin
                    r_cx <= r_cx + 1'b1;
                end
            end
            if (i_cmd.frame_done) begin
                r_blend <= r_seen && r_item.blend_over && r_item.alpha_present && !key_now;
                r_rl <= r_item.frame_x[XW-1:0];
                r_rt <= r_item.frame_y[YW-1:0];
                r_rw <= fw; r_rh <= fh;
                r_pcol <= '0; r_prow <= '0;
                r_key <= key_now; r_pkey <= key_now;
                r_pdisp <= r_item.dispose_background;
                r_seen <= 1'b1;
            end else if (i_cmd.pix_adv && pix_ok) begin
                if (nxt_col >= r_rw) begin
                    r_pcol <= '0;
                    r_prow <= r_prow + 1'b1;
                end else begin
                    r_pcol <= nxt_col[XW-1:0];
                end
            end
            o_res.key_frame <= i_cmd.frame_done ? key_now : r_key;
            o_res.clipped <= (o_st.action_pixel && !pix_in) ||
                             (o_st.action_read && !rd_in);
            if (o_st.action_read && rd_in && !i_cmd.load_item) begin
                o_res.read_red   <= r_rdata[23:16];
                o_res.read_green <= r_rdata[15:8];
                o_res.read_blue  <= r_rdata[7:0];
            end else begin
                o_res.read_red <= '0; o_res.read_green <= '0; o_res.read_blue <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_disp_done <= 1'b0;
        else if (i_cmd.load_item) r_disp_done <= 1'b0;
        else if (i_cmd.clr_start) r_disp_done <= 1'b1;
    end
    assign key_now_sel = r_disp_done || !o_st.need_disp;

endmodule

// ===== hdl/animated_frame_compositor.sv =====
// Channel  | Direction | Handshake          | Payload
// command  | in        | start / busy       | i_item (afc_pkg::t_in_item)
// result   | out       | o_valid, 1 cycle   | o_res  (afc_pkg::t_out_item)
// config   | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
// Copy pixels, dropped pixels and unused actions return from decode to idle; reads
// and blended pixels pass a read and a write state. A frame start sweeps the old
// clipped rectangle if it disposes, then the key check may sweep the whole canvas.
// The canvas memory has one port; sweeps and blends share it, so items wait.
// Reset is synchronous, active low; afterwards busy stays high while the whole
// canvas is cleared to black.
// The receiver cannot stall: o_valid marks the result for one cycle.
module animated_frame_compositor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  afc_pkg::t_in_item  i_item,
    output logic               o_valid,
    output afc_pkg::t_out_item o_res,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [6:0]         i_cfg_data
);

    afc_pkg::t_cmd    cmd;
    afc_pkg::t_status st;

    afc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    afc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_valid    (o_valid),
        .o_res      (o_res)
    );

endmodule
